/* rtl/tfp_pkg.sv */
// Shared types, constants and the CRC byte update for the telemetry frame parser.
package tfp_pkg;

   // Frame format
   localparam int MAX_PAYLOAD = 255;
   localparam logic [7:0] START_BYTE = 8'hFE;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   // Payload store holds the payload and both CRC bytes
   localparam int STORE_DEPTH = 257;
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int TABLE_DEPTH = 256;
   localparam int TABLE_AW = $clog2(TABLE_DEPTH);

   // Operation carried by one request transaction
   typedef enum logic [1:0] {
      MODE_RX       = 2'd0,
      MODE_TABLE_WR = 2'd1,
      MODE_STORE_RD = 2'd2,
      MODE_NOP      = 2'd3
   } mode_type;

   // Receive phase: the last frame byte that was taken
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_STX  = 3'd1,
      PH_LEN  = 3'd2,
      PH_SEQ  = 3'd3,
      PH_SYS  = 3'd4,
      PH_COMP = 3'd5,
      PH_BODY = 3'd6,
      PH_CRC1 = 3'd7
   } phase_type;

   // Header of a good frame
   typedef struct packed {
      logic [7:0] length;
      logic [7:0] component;
      logic [7:0] system;
      logic [7:0] seq;
      logic [7:0] id;
   } header_type;

   // One response transaction
   typedef struct packed {
      logic        frame_done;
      logic        error_now;
      logic [7:0]  next_seq;
      logic [15:0] good_frames;
      header_type  header;
      logic [7:0]  read_byte;
   } rsp_type;

   // X.25 CRC, one byte
   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ acc[7:0];
      t = t ^ {t[3:0], 4'h0};
      return {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
   endfunction

endpackage

/* rtl/telemetry_frame_parser.sv */
// Top level of the telemetry frame parser: byte parser, CRC, stores and response stages.
//
// Usage: each request transaction carries a mode, a data byte and an index.
// Mode 0 feeds one line byte to the frame parser, mode 1 writes one entry of
// the per-message extra-CRC table, mode 2 reads the payload store (the bytes of
// the last frame body and its CRC), mode 3 does nothing. Every request gives
// exactly one response transaction with the frame status flags, the header of
// the last good frame, the good-frame count and, for mode 2, the read byte.
// The csr_ port writes crc_extra_enable; write it only while the block is idle.
// Path: a response goes through the response stage, then the output register.
// Throughput: one transaction per cycle while req_stall is low. Parser state,
// CRC update and RAM writes complete in the cycle of acceptance; RAM reads are
// registered. The extra-CRC byte for the message id is fetched from its RAM
// when the id byte arrives.
// Stall: a response held by rsp_stall keeps the output register; one more
// request is still taken into the response stage, then req_stall rises.
// Reset: synchronous; clears the parser, counters, header, both response
// stages and the table valid bits, so the extra-CRC table reads as all zeros.
module telemetry_frame_parser
   import tfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [8:0]  req_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_done,
   output logic        rsp_error_now,
   output logic [7:0]  rsp_next_seq,
   output logic [15:0] rsp_good_frames,
   output logic [7:0]  rsp_frame_id,
   output logic [7:0]  rsp_frame_seq,
   output logic [7:0]  rsp_frame_system,
   output logic [7:0]  rsp_frame_component,
   output logic [7:0]  rsp_frame_length,
   output logic [7:0]  rsp_read_byte
);

   // ---------------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------------
   logic                 crc_extra_enable_ff;

   phase_type            phase_ff, phase_in;
   logic [15:0]          crc_ff, crc_in;
   logic [7:0]           len_ff, len_in;
   logic [STORE_AW-1:0]  count_ff, count_in;
   logic [7:0]           seq_ff, seq_in;
   logic [7:0]           sys_ff, sys_in;
   logic [7:0]           comp_ff, comp_in;
   logic [7:0]           id_ff, id_in;
   header_type           header_ff, header_in;
   logic [7:0]           last_seq_ff, last_seq_in;
   logic [15:0]          good_ff, good_in;

   logic                 done_now;
   logic                 err_now;
   logic                 st_we;
   logic [STORE_AW-1:0]  st_waddr;
   logic                 st_re;
   logic [7:0]           st_rdata;

   logic [TABLE_DEPTH-1:0] ext_valid_ff;
   logic                 tbl_we;
   logic                 tbl_re;
   logic [7:0]           tbl_rdata;
   logic                 fetch_pend_ff;
   logic                 fetch_valid_ff;
   logic [7:0]           extra_ff, extra_in;
   logic [7:0]           extra_cur;
   logic [15:0]          crc_x;

   mode_type             mode;
   logic                 accept;
   logic                 is_rx;
   logic                 rd_sel;

   logic                 r1_valid_ff;
   rsp_type              r1_ff;
   logic                 r1_rd_sel_ff;
   logic                 o_valid_ff;
   rsp_type              o_ff;
   rsp_type              o_in;
   logic                 o_take;
   rsp_type              r1_in;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign o_take    = !o_valid_ff || !rsp_stall;
   assign req_stall = r1_valid_ff && !o_take;
   assign accept    = req_valid && !req_stall;
   assign mode      = mode_type'(req_mode);
   assign is_rx     = accept && (mode == MODE_RX);
   assign rd_sel    = (mode == MODE_STORE_RD) && (req_index <= 9'(STORE_DEPTH - 1));

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_extra_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         crc_extra_enable_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Extra-CRC table: RAM plus valid bits; extra_ff tracks table[id_ff]
   // ---------------------------------------------------------------------
   assign tbl_we = accept && (mode == MODE_TABLE_WR) && !req_index[8];

   tfp_ram #(
      .Width (8),
      .Depth (TABLE_DEPTH)
   ) u_extra_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (req_index[TABLE_AW-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (tbl_re),
      .rd_addr (req_data_byte),
      .rd_data (tbl_rdata)
   );

   // pending fetch returns RAM data; unwritten entries read as zero
   assign extra_cur = fetch_pend_ff ? (fetch_valid_ff ? tbl_rdata : 8'h00) : extra_ff;
   assign extra_in  = (tbl_we && (req_index[TABLE_AW-1:0] == id_ff)) ? req_data_byte
                                                                     : extra_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_valid_ff  <= '0;
         fetch_pend_ff <= 1'b0;
         extra_ff      <= 8'h00;
      end else begin
         if (tbl_we) begin
            ext_valid_ff[req_index[TABLE_AW-1:0]] <= 1'b1;
         end
         fetch_pend_ff <= tbl_re;
         extra_ff      <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      fetch_valid_ff <= ext_valid_ff[req_data_byte];
   end

   // ---------------------------------------------------------------------
   // Payload store
   // ---------------------------------------------------------------------
   assign st_re = accept && rd_sel;

   tfp_ram #(
      .Width (8),
      .Depth (STORE_DEPTH)
   ) u_payload_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (req_data_byte),
      .rd_en   (st_re),
      .rd_addr (req_index),
      .rd_data (st_rdata)
   );

   // ---------------------------------------------------------------------
   // Parser state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         crc_ff      <= CRC_SEED;
         len_ff      <= 8'h00;
         count_ff    <= '0;
         seq_ff      <= 8'h00;
         sys_ff      <= 8'h00;
         comp_ff     <= 8'h00;
         id_ff       <= 8'h00;
         header_ff   <= '0;
         last_seq_ff <= 8'h00;
         good_ff     <= 16'h0000;
      end else begin
         phase_ff    <= phase_in;
         crc_ff      <= crc_in;
         len_ff      <= len_in;
         count_ff    <= count_in;
         seq_ff      <= seq_in;
         sys_ff      <= sys_in;
         comp_ff     <= comp_in;
         id_ff       <= id_in;
         header_ff   <= header_in;
         last_seq_ff <= last_seq_in;
         good_ff     <= good_in;
      end
   end

   // CRC with the per-message extra byte folded in when crc_extra_enable is set
   assign crc_x = crc_extra_enable_ff ? crc_step(crc_ff, extra_cur) : crc_ff;

   // ---------------------------------------------------------------------
   // Parser next state
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in    = phase_ff;
      crc_in      = crc_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      seq_in      = seq_ff;
      sys_in      = sys_ff;
      comp_in     = comp_ff;
      id_in       = id_ff;
      header_in   = header_ff;
      last_seq_in = last_seq_ff;
      good_in     = good_ff;
      done_now    = 1'b0;
      err_now     = 1'b0;
      st_we       = 1'b0;
      st_waddr    = count_ff;
      tbl_re      = 1'b0;

      if (is_rx) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_data_byte == START_BYTE) begin
                  phase_in = PH_STX;
                  len_in   = 8'h00;
                  crc_in   = CRC_SEED;
               end
            end
            PH_STX: begin
               if (req_data_byte > 8'(MAX_PAYLOAD)) begin
                  err_now  = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  len_in   = req_data_byte;
                  count_in = '0;
                  crc_in   = crc_step(crc_ff, req_data_byte);
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               seq_in   = req_data_byte;
               crc_in   = crc_step(crc_ff, req_data_byte);
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               sys_in   = req_data_byte;
               crc_in   = crc_step(crc_ff, req_data_byte);
               phase_in = PH_SYS;
            end
            PH_SYS: begin
               comp_in  = req_data_byte;
               crc_in   = crc_step(crc_ff, req_data_byte);
               phase_in = PH_COMP;
            end
            PH_COMP: begin
               id_in    = req_data_byte;
               crc_in   = crc_step(crc_ff, req_data_byte);
               phase_in = PH_BODY;
               tbl_re   = 1'b1;
            end
            PH_BODY: begin
               if (count_ff < {1'b0, len_ff}) begin
                  // payload byte
                  st_we    = 1'b1;
                  count_in = count_ff + 1'b1;
                  crc_in   = crc_step(crc_ff, req_data_byte);
               end else begin
                  // low CRC byte
                  crc_in = crc_x;
                  if (req_data_byte != crc_x[7:0]) begin
                     err_now  = 1'b1;
                     phase_in = PH_IDLE;
                     if (req_data_byte == START_BYTE) begin
                        phase_in = PH_STX;
                        len_in   = 8'h00;
                        crc_in   = CRC_SEED;
                     end
                  end else begin
                     st_we    = 1'b1;
                     phase_in = PH_CRC1;
                  end
               end
            end
            PH_CRC1: begin
               // high CRC byte
               if (req_data_byte != crc_ff[15:8]) begin
                  err_now  = 1'b1;
                  phase_in = PH_IDLE;
                  if (req_data_byte == START_BYTE) begin
                     phase_in = PH_STX;
                     len_in   = 8'h00;
                     crc_in   = CRC_SEED;
                  end
               end else begin
                  st_we       = 1'b1;
                  st_waddr    = count_ff + 1'b1;
                  phase_in    = PH_IDLE;
                  done_now    = 1'b1;
                  last_seq_in = seq_ff;
                  good_in     = good_ff + 16'd1;
                  header_in   = '{length: len_ff, component: comp_ff, system: sys_ff,
                                  seq: seq_ff, id: id_ff};
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Response stage and output register
   // ---------------------------------------------------------------------
   always_comb begin
      r1_in.frame_done  = done_now;
      r1_in.error_now   = err_now;
      r1_in.next_seq    = last_seq_in + 8'd1;
      r1_in.good_frames = good_in;
      r1_in.header      = header_in;
      r1_in.read_byte   = 8'h00;
   end

   // store read data joins the response on its way to the output register
   always_comb begin
      o_in           = r1_ff;
      o_in.read_byte = r1_rd_sel_ff ? st_rdata : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         r1_valid_ff <= accept || req_stall;
         if (o_take) begin
            o_valid_ff <= r1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r1_ff        <= r1_in;
         r1_rd_sel_ff <= rd_sel;
      end
      if (o_take && r1_valid_ff) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid           = o_valid_ff;
   assign rsp_frame_done      = o_ff.frame_done;
   assign rsp_error_now       = o_ff.error_now;
   assign rsp_next_seq        = o_ff.next_seq;
   assign rsp_good_frames     = o_ff.good_frames;
   assign rsp_frame_id        = o_ff.header.id;
   assign rsp_frame_seq       = o_ff.header.seq;
   assign rsp_frame_system    = o_ff.header.system;
   assign rsp_frame_component = o_ff.header.component;
   assign rsp_frame_length    = o_ff.header.length;
   assign rsp_read_byte       = o_ff.read_byte;

endmodule

/* rtl/tfp_ram.sv */
// Generic simple dual-port RAM with registered read.
module tfp_ram #(
   parameter int Width = 8,
   parameter int Depth = 256,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tfp_checker.sv */
// Port-level assertions for the telemetry frame parser, bound to the top level.
module tfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_frame_done,
   input logic        rsp_error_now,
   input logic [7:0]  rsp_next_seq,
   input logic [7:0]  rsp_frame_seq,
   input logic [15:0] rsp_good_frames
);

   // a byte cannot both finish a frame and flag an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_done && rsp_error_now))
      else $error("frame_done and error_now both set");

   // recorded sequence and latched header sequence always agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_seq == 8'(rsp_frame_seq + 8'd1)))
      else $error("next_seq does not follow frame_seq");

   // no response transaction right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_good_frames)
                                    && $stable(rsp_frame_done)))
      else $error("stalled response changed");

endmodule

bind telemetry_frame_parser tfp_checker u_tfp_checker (.*);

/* test/tb_telemetry_frame_parser.sv */
// Self-checking testbench for the telemetry frame parser: frames, CRC extra, table and store.
module tb_telemetry_frame_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import tfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 400;

   // Ways a frame on the line can be damaged
   typedef enum logic [2:0] {
      FLAW_NONE           = 3'd0,
      FLAW_CRC_LOW        = 3'd1,
      FLAW_CRC_LOW_START  = 3'd2,
      FLAW_CRC_HIGH       = 3'd3,
      FLAW_CRC_HIGH_START = 3'd4,
      FLAW_CUT            = 3'd5,
      FLAW_BYTE           = 3'd6
   } frame_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_NOP;
   logic [7:0]  req_data_byte = 8'h00;
   logic [8:0]  req_index = 9'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_frame_done;
   logic        rsp_error_now;
   logic [7:0]  rsp_next_seq;
   logic [15:0] rsp_good_frames;
   logic [7:0]  rsp_frame_id;
   logic [7:0]  rsp_frame_seq;
   logic [7:0]  rsp_frame_system;
   logic [7:0]  rsp_frame_component;
   logic [7:0]  rsp_frame_length;
   logic [7:0]  rsp_read_byte;

   telemetry_frame_parser dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_data_byte       (req_data_byte),
      .req_index           (req_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_error_now       (rsp_error_now),
      .rsp_next_seq        (rsp_next_seq),
      .rsp_good_frames     (rsp_good_frames),
      .rsp_frame_id        (rsp_frame_id),
      .rsp_frame_seq       (rsp_frame_seq),
      .rsp_frame_system    (rsp_frame_system),
      .rsp_frame_component (rsp_frame_component),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_read_byte       (rsp_read_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser shadow state
   bit          crc_extra_en;
   phase_type   rx_phase;
   logic [15:0] rx_crc;
   logic [7:0]  rx_len;
   logic [8:0]  body_count;
   logic [7:0]  hdr_seq, hdr_sys, hdr_comp, hdr_id;
   header_type  good_header;
   logic [7:0]  seq_seen;
   logic [15:0] good_total;
   logic [7:0]  store_mem [0:STORE_DEPTH-1];
   bit          store_valid [0:STORE_DEPTH-1];
   int          store_top;
   logic [7:0]  extra_mem [0:TABLE_DEPTH-1];

   rsp_type     response_due [$];
   rsp_type     rsp_want;
   int          mismatch_count = 0;
   int          requests_sent = 0;
   int          gap_streak = 0;
   int          stall_left = 0;
   int          free_left = 0;
   int          quiet_cycles = 0;

   // Bitwise X.25 (reflected 0x1021) update over one byte
   function automatic logic [15:0] x25_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      return c;
   endfunction

   function automatic void keep_byte(input logic [8:0] addr, input logic [7:0] b);
      store_mem[addr] = b;
      store_valid[addr] = 1'b1;
      if (int'(addr) > store_top)
         store_top = int'(addr);
   endfunction

   // Drop back to idle; a start byte opens a new frame at once
   function automatic void resync(input logic [7:0] b);
      rx_phase = PH_IDLE;
      if (b == START_BYTE) begin
         rx_phase = PH_STX;
         rx_len = 8'h00;
         rx_crc = CRC_SEED;
      end
   endfunction

   // Advance the shadow parser by one transaction and form its response
   function automatic rsp_type parser_response(input mode_type mode, input logic [7:0] b,
                                               input logic [8:0] idx);
      rsp_type r;
      r = '0;
      case (mode)
         MODE_RX: begin
            case (rx_phase)
               PH_IDLE: resync(b);
               PH_STX: begin
                  if (int'(b) > MAX_PAYLOAD) begin
                     r.error_now = 1'b1;
                     rx_phase = PH_IDLE;
                  end else begin
                     rx_len = b;
                     body_count = 9'd0;
                     rx_crc = x25_update(rx_crc, b);
                     rx_phase = PH_LEN;
                  end
               end
               PH_LEN: begin
                  hdr_seq = b;
                  rx_crc = x25_update(rx_crc, b);
                  rx_phase = PH_SEQ;
               end
               PH_SEQ: begin
                  hdr_sys = b;
                  rx_crc = x25_update(rx_crc, b);
                  rx_phase = PH_SYS;
               end
               PH_SYS: begin
                  hdr_comp = b;
                  rx_crc = x25_update(rx_crc, b);
                  rx_phase = PH_COMP;
               end
               PH_COMP: begin
                  hdr_id = b;
                  rx_crc = x25_update(rx_crc, b);
                  rx_phase = PH_BODY;
               end
               PH_BODY: begin
                  if (body_count < {1'b0, rx_len}) begin
                     keep_byte(body_count, b);
                     body_count = body_count + 9'd1;
                     rx_crc = x25_update(rx_crc, b);
                  end else begin
                     if (crc_extra_en)
                        rx_crc = x25_update(rx_crc, extra_mem[hdr_id]);
                     if (b != rx_crc[7:0]) begin
                        r.error_now = 1'b1;
                        resync(b);
                     end else begin
                        keep_byte(body_count, b);
                        rx_phase = PH_CRC1;
                     end
                  end
               end
               default: begin
                  if (b != rx_crc[15:8]) begin
                     r.error_now = 1'b1;
                     resync(b);
                  end else begin
                     keep_byte(body_count + 9'd1, b);
                     rx_phase = PH_IDLE;
                     r.frame_done = 1'b1;
                     seq_seen = hdr_seq;
                     good_total = good_total + 16'd1;
                     good_header.length = rx_len;
                     good_header.component = hdr_comp;
                     good_header.system = hdr_sys;
                     good_header.seq = hdr_seq;
                     good_header.id = hdr_id;
                  end
               end
            endcase
         end
         MODE_TABLE_WR: begin
            if (int'(idx) < TABLE_DEPTH)
               extra_mem[idx[7:0]] = b;
         end
         MODE_STORE_RD: begin
            if (int'(idx) < STORE_DEPTH)
               r.read_byte = store_mem[idx];
         end
         default: ;
      endcase
      r.next_seq = seq_seen + 8'd1;
      r.good_frames = good_total;
      r.header = good_header;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Send one request transaction, record its expected response, then maybe idle
   task automatic send_request(input mode_type mode, input logic [7:0] b, input logic [8:0] idx);
      int gap;
      int roll;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data_byte <= b;
      req_index <= idx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      response_due.push_back(parser_response(mode, b, idx));
      requests_sent++;
      gap = 0;
      if (gap_streak > 0) begin
         gap_streak--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll >= 97)
            gap = $urandom_range(20, 40);
         else if (roll >= 85)
            gap = $urandom_range(4, 12);
         else if (roll >= 55)
            gap = $urandom_range(1, 3);
         if ($urandom_range(0, 49) == 0)
            gap_streak = $urandom_range(40, 120);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_index <= 9'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Build a frame from the shadow table and setting, damage it if asked, and send it
   task automatic send_frame(input logic [7:0] len, input logic [7:0] seq, input logic [7:0] sys,
                             input logic [7:0] comp, input logic [7:0] id,
                             input frame_flaw_type flaw);
      logic [7:0]  line_bytes [$];
      logic [15:0] crc;
      int          base, n, pos, keep;
      // a frame left open earlier is flushed with line noise first
      while (rx_phase != PH_IDLE && rx_phase != PH_STX)
         send_request(MODE_RX, 8'($urandom), 9'($urandom));
      if (rx_phase == PH_IDLE)
         line_bytes.push_back(START_BYTE);
      base = line_bytes.size();
      line_bytes.push_back(len);
      line_bytes.push_back(seq);
      line_bytes.push_back(sys);
      line_bytes.push_back(comp);
      line_bytes.push_back(id);
      repeat (int'(len)) line_bytes.push_back(8'($urandom));
      crc = CRC_SEED;
      for (int i = base; i < line_bytes.size(); i++)
         crc = x25_update(crc, line_bytes[i]);
      if (crc_extra_en)
         crc = x25_update(crc, extra_mem[id]);
      line_bytes.push_back(crc[7:0]);
      line_bytes.push_back(crc[15:8]);
      n = line_bytes.size();
      case (flaw)
         FLAW_CRC_LOW, FLAW_CRC_HIGH: begin
            pos = (flaw == FLAW_CRC_LOW) ? n - 2 : n - 1;
            line_bytes[pos] = line_bytes[pos] ^ 8'($urandom_range(1, 255));
         end
         FLAW_CRC_LOW_START, FLAW_CRC_HIGH_START: begin
            pos = (flaw == FLAW_CRC_LOW_START) ? n - 2 : n - 1;
            line_bytes[pos] = (line_bytes[pos] == START_BYTE) ? ~START_BYTE : START_BYTE;
            // the sender stops at the bad byte so the restarted frame is not fed a length
            if (flaw == FLAW_CRC_LOW_START)
               void'(line_bytes.pop_back());
         end
         FLAW_BYTE: begin
            pos = $urandom_range(base + 1, n - 3);
            line_bytes[pos] = line_bytes[pos] ^ 8'($urandom_range(1, 255));
         end
         FLAW_CUT: begin
            keep = $urandom_range(1, n - 1);
            while (line_bytes.size() > keep)
               void'(line_bytes.pop_back());
         end
         default: ;
      endcase
      foreach (line_bytes[i])
         send_request(MODE_RX, line_bytes[i], 9'($urandom));
   endtask

   // Wait for the pipeline to empty, then write crc_extra_enable
   task automatic set_crc_extra(input bit en);
      req_valid <= 1'b0;
      while (response_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= en;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      crc_extra_en = en;
   endtask

   // Extra table writes at index 5, at the last entry and past the end, no-op, store reads out of range
   task automatic test_table_access();
      send_request(MODE_TABLE_WR, 8'hA5, 9'd5);
      send_request(MODE_TABLE_WR, 8'hFF, 9'd255);
      send_request(MODE_TABLE_WR, 8'h3C, 9'd256);
      send_request(MODE_NOP, 8'hFF, 9'h1FF);
      send_request(MODE_STORE_RD, 8'h00, 9'h1FF);
      send_request(MODE_STORE_RD, 8'hFF, 9'd257);
   endtask

   // Empty frame, sequence wrap, store reads of its CRC bytes, CRC low byte bad and equal to the start byte
   task automatic test_short_frames();
      send_request(MODE_RX, 8'h00, 9'd0);
      send_frame(8'd0, 8'hFF, 8'h00, 8'hFF, 8'd5, FLAW_NONE);
      send_request(MODE_STORE_RD, 8'h00, 9'd0);
      send_request(MODE_STORE_RD, 8'h00, 9'd1);
      send_frame(8'd1, 8'h00, 8'hFF, 8'h00, 8'hFF, FLAW_CRC_LOW_START);
   endtask

   // Frames with the per-message extra byte left out and added back
   task automatic test_crc_extra_setting();
      for (int s = 0; s < 2; s++) begin
         set_crc_extra(s == 1);
         send_frame(8'd2, 8'($urandom), 8'($urandom), 8'($urandom), 8'd5, FLAW_NONE);
         send_frame(8'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255, FLAW_NONE);
         send_frame(8'd1, 8'($urandom), 8'($urandom), 8'($urandom), 8'd5, FLAW_CRC_HIGH);
      end
   endtask

   // Largest payload fills the store to its last address
   task automatic test_max_length_frame();
      send_frame(8'd255, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), FLAW_NONE);
      send_request(MODE_STORE_RD, 8'h00, 9'd255);
      send_request(MODE_STORE_RD, 8'h00, 9'd256);
      send_request(MODE_STORE_RD, 8'h00, 9'd0);
   endtask

   // Mostly good frames with random content, plus damage, noise, table and store traffic
   task automatic test_random_traffic();
      int         phase_end;
      int         roll;
      logic [7:0] len, id;
      logic [8:0] addr;
      for (int round = 0; round < 4; round++) begin
         set_crc_extra(round % 2 == 1);
         phase_end = requests_sent + RANDOM_ITEMS / 4;
         while (requests_sent < phase_end) begin
            roll = $urandom_range(0, 99);
            len = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 8))
                                               : 8'($urandom_range(9, 40));
            id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            if (roll < 62) begin
               send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), id, FLAW_NONE);
            end else if (roll < 74) begin
               send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), id,
                          frame_flaw_type'(3'($urandom_range(1, 6))));
            end else if (roll < 80) begin
               // line noise between frames
               repeat ($urandom_range(1, 4)) begin
                  if (rx_phase == PH_IDLE)
                     send_request(MODE_RX, 8'($urandom), 9'($urandom));
               end
            end else if (roll < 88) begin
               addr = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 7)) : 9'($urandom);
               send_request(MODE_TABLE_WR, 8'($urandom), addr);
            end else if (roll < 97) begin
               // only entries already written are read inside the store
               if (store_valid[0] && $urandom_range(0, 4) != 0)
                  addr = 9'($urandom_range(0, store_top));
               else
                  addr = 9'($urandom_range(STORE_DEPTH, 511));
               if (int'(addr) < STORE_DEPTH && !store_valid[addr])
                  addr = 9'(STORE_DEPTH);
               send_request(MODE_STORE_RD, 8'($urandom), addr);
            end else begin
               send_request(MODE_NOP, 8'($urandom), 9'($urandom));
            end
         end
      end
   endtask

   // Response checker and random response stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (response_due.size() == 0) begin
            report_mismatch("response transaction with none expected");
         end else begin
            rsp_want = response_due.pop_front();
            if (rsp_frame_done !== rsp_want.frame_done)
               report_mismatch($sformatf("frame_done got %0h want %0h",
                                         rsp_frame_done, rsp_want.frame_done));
            if (rsp_error_now !== rsp_want.error_now)
               report_mismatch($sformatf("error_now got %0h want %0h",
                                         rsp_error_now, rsp_want.error_now));
            if (rsp_next_seq !== rsp_want.next_seq)
               report_mismatch($sformatf("next_seq got %0h want %0h",
                                         rsp_next_seq, rsp_want.next_seq));
            if (rsp_good_frames !== rsp_want.good_frames)
               report_mismatch($sformatf("good_frames got %0h want %0h",
                                         rsp_good_frames, rsp_want.good_frames));
            if (rsp_frame_id !== rsp_want.header.id)
               report_mismatch($sformatf("frame_id got %0h want %0h",
                                         rsp_frame_id, rsp_want.header.id));
            if (rsp_frame_seq !== rsp_want.header.seq)
               report_mismatch($sformatf("frame_seq got %0h want %0h",
                                         rsp_frame_seq, rsp_want.header.seq));
            if (rsp_frame_system !== rsp_want.header.system)
               report_mismatch($sformatf("frame_system got %0h want %0h",
                                         rsp_frame_system, rsp_want.header.system));
            if (rsp_frame_component !== rsp_want.header.component)
               report_mismatch($sformatf("frame_component got %0h want %0h",
                                         rsp_frame_component, rsp_want.header.component));
            if (rsp_frame_length !== rsp_want.header.length)
               report_mismatch($sformatf("frame_length got %0h want %0h",
                                         rsp_frame_length, rsp_want.header.length));
            if (rsp_read_byte !== rsp_want.read_byte)
               report_mismatch($sformatf("read_byte got %0h want %0h",
                                         rsp_read_byte, rsp_want.read_byte));
         end
      end
      // stall runs: mostly short, a few long, with stall-free stretches
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left > 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else begin
         rsp_stall <= 1'b0;
         free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      crc_extra_en = 1'b1;
      rx_phase = PH_IDLE;
      rx_crc = CRC_SEED;
      rx_len = 8'h00;
      body_count = 9'd0;
      hdr_seq = 8'h00;
      hdr_sys = 8'h00;
      hdr_comp = 8'h00;
      hdr_id = 8'h00;
      good_header = '0;
      seq_seen = 8'h00;
      good_total = 16'h0000;
      store_top = -1;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_mem[i] = 8'h00;
         store_valid[i] = 1'b0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
         extra_mem[i] = 8'h00;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_table_access();
      test_short_frames();
      test_crc_extra_setting();
      test_max_length_frame();
      test_random_traffic();

      req_valid <= 1'b0;
      while (response_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
rtl/tfp_pkg.sv
rtl/tfp_ram.sv
rtl/telemetry_frame_parser.sv
rtl/tfp_checker.sv
test/tb_telemetry_frame_parser.sv
